[rtl/mbrtu_pkg.sv]
// Package for the Modbus RTU master framer.
// Holds item codes, command and result types, CRC-16 table functions and sizes.
// Used by every module of the block; depends on nothing.
package mbrtu_pkg;

  localparam int unsigned MAX_WORDS    = 125;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W  = QUEUE_PTR_W + 1;
  localparam int unsigned STEP_W       = 3;

  localparam logic [7:0]  FN_READ_INPUT  = 8'h04;
  localparam logic [7:0]  FN_WRITE_ONE   = 8'h06;
  localparam logic [7:0]  FN_WRITE_MULTI = 8'h10;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;

  typedef enum logic [2:0] {
    FUNC_READ   = 3'd0,
    FUNC_WRITE1 = 3'd1,
    FUNC_MHDR   = 3'd2,
    FUNC_MVAL   = 3'd3,
    FUNC_RXBYTE = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    KIND_TX     = 2'd0,
    KIND_WORD   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef struct packed {
    func_e       op;
    logic [7:0]  addr;
    logic [15:0] reg_addr;
    logic [6:0]  cnt;
    logic [15:0] value;
    logic        last;
    logic [7:0]  rx;
  } cmd_t;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         byte_out;
    logic signed [15:0] data_word;
    logic               crc_ok;
    logic               frame_end;
  } result_t;

  function automatic logic [15:0] crc_tab_f(input logic [7:0] idx);
    logic [15:0] c;
    c = {8'h00, idx};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] crc_feed_f(input logic [15:0] crc, input logic [7:0] data);
    return {8'h00, crc[15:8]} ^ crc_tab_f(data ^ crc[7:0]);
  endfunction

endpackage

[rtl/modbus_rtu_master_framer.sv]
// Top level of the Modbus RTU master framer.
// Instantiates mbrtu_front, mbrtu_queue and mbrtu_back; depends on mbrtu_pkg.
//
// Usage: requests and received response bytes enter on the slave stream. tuser
// carries the item code (read, write single, multi header, multi value, response
// byte) and tlast marks the final value of a multi write. The master stream
// carries transmit bytes, read data words and the read status; tlast marks the
// last result caused by one input item.
// The front decodes each item into a command and pushes it into a four-entry
// queue; it stalls only when the queue is full. The back runs one command at a
// time and, while the output register is free, produces one result per cycle into it.
// With an empty queue and a free output, the first result of an item is held
// in the queue and then the output register before it is valid on the master
// stream. Frame bytes go out in order, the CRC pair at the end of each frame; an
// ignored multi value or response byte gives no result, and an item with an
// unused code is dropped by the front.
// The single CRC table lookup in the back sets the one-byte-per-cycle pace.
// Reset empties the queue, clears the output valid and parse state, and presets both CRCs.
// When the receiver stalls, the output holds and the back waits at its next
// result; the queue keeps taking items until it fills.
module modbus_rtu_master_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // slave_addr[7:0], reg_number[23:8], word_count[30:24], reg_value[46:31],
  // rx_byte[54:47], zero[55]
  input  logic [55:0] s_axis_tdata_i,
  // func[2:0]
  input  logic [2:0]  s_axis_tuser_i,
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // byte_out[7:0], data_word[23:8], crc_ok[24], zero[31:25]
  output logic [31:0] m_axis_tdata_o,
  // kind[1:0]
  output logic [1:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  logic               q_full, q_push, q_pop, head_valid;
  mbrtu_pkg::cmd_t    push_cmd, head_cmd;
  mbrtu_pkg::result_t res;

  mbrtu_front u_front (
    .s_valid_i (s_axis_tvalid_i),
    .s_data_i  (s_axis_tdata_i),
    .s_user_i  (s_axis_tuser_i),
    .s_last_i  (s_axis_tlast_i),
    .s_ready_o (s_axis_tready_o),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_cmd_o   (push_cmd)
  );

  mbrtu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_cmd_i   (push_cmd),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd)
  );

  mbrtu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_cmd_i   (head_cmd),
    .pop_o        (q_pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_res_o    (res),
    .out_ready_i  (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {7'b0, res.crc_ok, res.data_word, res.byte_out};
  assign m_axis_tuser_o = res.kind;
  assign m_axis_tlast_o = res.frame_end;

  a_status_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == mbrtu_pkg::KIND_STATUS |-> m_axis_tlast_o)
    else $error("Read status is not the last result of its item.");

  a_kind_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o == mbrtu_pkg::KIND_TX ||
                         m_axis_tuser_o == mbrtu_pkg::KIND_WORD ||
                         m_axis_tuser_o == mbrtu_pkg::KIND_STATUS))
    else $error("Result kind out of range.");

  a_byte_only_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != mbrtu_pkg::KIND_TX |-> m_axis_tdata_o[7:0] == 8'h00)
    else $error("Frame byte set on a parse result.");

  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> head_valid)
    else $error("Back retired a command from an empty queue.");

endmodule

[rtl/mbrtu_front.sv]
// Front part of the Modbus RTU master framer: accepts input items and classifies them.
// Turns each item with a used code into a command for the queue; depends on mbrtu_pkg.
module mbrtu_front (
  input  logic               s_valid_i,
  input  logic [55:0]        s_data_i,
  input  logic [2:0]         s_user_i,
  input  logic               s_last_i,
  output logic               s_ready_o,
  input  logic               q_full_i,
  output logic               q_push_o,
  output mbrtu_pkg::cmd_t    q_cmd_o
);

  logic [6:0]  raw_cnt;
  logic [15:0] raw_reg;
  logic        known;

  assign raw_reg = s_data_i[23:8];
  assign raw_cnt = s_data_i[30:24];

  always_comb begin
    q_cmd_o.op       = mbrtu_pkg::func_e'(s_user_i);
    q_cmd_o.addr     = s_data_i[7:0];
    q_cmd_o.reg_addr = raw_reg - 16'd1;
    q_cmd_o.cnt      = (raw_cnt > 7'(mbrtu_pkg::MAX_WORDS)) ?
                       7'(mbrtu_pkg::MAX_WORDS) : raw_cnt;
    q_cmd_o.value    = s_data_i[46:31];
    q_cmd_o.last     = s_last_i;
    q_cmd_o.rx       = s_data_i[54:47];
    unique case (mbrtu_pkg::func_e'(s_user_i))
      mbrtu_pkg::FUNC_READ,
      mbrtu_pkg::FUNC_WRITE1,
      mbrtu_pkg::FUNC_MHDR,
      mbrtu_pkg::FUNC_MVAL,
      mbrtu_pkg::FUNC_RXBYTE: known = 1'b1;
      default:                known = 1'b0;
    endcase
  end

  assign s_ready_o = !q_full_i;
  assign q_push_o  = s_valid_i && !q_full_i && known;

endmodule

[rtl/mbrtu_queue.sv]
// Short command queue between the front and back parts of the framer.
// Small register FIFO of commands; depends on mbrtu_pkg.
module mbrtu_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mbrtu_pkg::cmd_t    push_cmd_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               head_valid_o,
  output mbrtu_pkg::cmd_t    head_cmd_o
);

  mbrtu_pkg::cmd_t                     slot_q [mbrtu_pkg::QUEUE_DEPTH];
  logic [mbrtu_pkg::QUEUE_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [mbrtu_pkg::QUEUE_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [mbrtu_pkg::QUEUE_CNT_W-1:0]   count_q, count_d;
  logic                                do_push, do_pop;

  assign full_o       = (count_q == mbrtu_pkg::QUEUE_CNT_W'(mbrtu_pkg::QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_cmd_o   = slot_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

[rtl/mbrtu_back.sv]
// Back part of the framer: emits frame bytes with CRC-16 and parses read responses.
// One result per cycle into an output register while it is free; depends on mbrtu_pkg.
module mbrtu_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_valid_i,
  input  mbrtu_pkg::cmd_t      head_cmd_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  output mbrtu_pkg::result_t   out_res_o,
  input  logic                 out_ready_i
);

  logic [mbrtu_pkg::STEP_W-1:0] step_q, step_d;
  logic [15:0] tx_crc_q, tx_crc_d;
  logic [15:0] rx_crc_q, rx_crc_d;
  logic [7:0]  rx_pos_q, rx_pos_d;
  logic [6:0]  exp_words_q, exp_words_d;
  logic [7:0]  held_hi_q, held_hi_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic        multi_open_q, multi_open_d;
  logic        out_valid_q, out_valid_d;
  mbrtu_pkg::result_t out_res_q, out_res_d;

  logic        can_load, fire, emit, last_step, feed;
  logic [7:0]  tx_byte, feed_byte, dlen3;
  logic [15:0] crc_in, crc_next;
  mbrtu_pkg::cmd_t    cmd;
  mbrtu_pkg::result_t res;

  assign cmd      = head_cmd_i;
  assign can_load = !out_valid_q || out_ready_i;
  assign dlen3    = 8'({exp_words_q, 1'b0}) + 8'd3;
  assign crc_next = mbrtu_pkg::crc_feed_f(crc_in, feed_byte);

  always_comb begin
    emit      = 1'b0;
    last_step = 1'b1;
    feed      = 1'b0;
    tx_byte   = 8'h00;
    res       = '0;
    crc_in    = tx_crc_q;
    unique case (cmd.op)
      mbrtu_pkg::FUNC_READ, mbrtu_pkg::FUNC_WRITE1, mbrtu_pkg::FUNC_MHDR: begin
        emit      = 1'b1;
        last_step = (cmd.op == mbrtu_pkg::FUNC_MHDR) ? (step_q == 3'd6) : (step_q == 3'd7);
        feed      = 1'b1;
        if (step_q == 3'd0) begin
          crc_in = mbrtu_pkg::CRC_INIT;
        end
        unique case (step_q)
          3'd0: tx_byte = cmd.addr;
          3'd1: begin
            unique case (cmd.op)
              mbrtu_pkg::FUNC_READ:   tx_byte = mbrtu_pkg::FN_READ_INPUT;
              mbrtu_pkg::FUNC_WRITE1: tx_byte = mbrtu_pkg::FN_WRITE_ONE;
              default:                tx_byte = mbrtu_pkg::FN_WRITE_MULTI;
            endcase
          end
          3'd2: tx_byte = cmd.reg_addr[15:8];
          3'd3: tx_byte = cmd.reg_addr[7:0];
          3'd4: tx_byte = (cmd.op == mbrtu_pkg::FUNC_WRITE1) ? cmd.value[15:8] : 8'h00;
          3'd5: tx_byte = (cmd.op == mbrtu_pkg::FUNC_WRITE1) ? cmd.value[7:0] : {1'b0, cmd.cnt};
          3'd6: begin
            if (cmd.op == mbrtu_pkg::FUNC_MHDR) begin
              tx_byte = {cmd.cnt, 1'b0};
            end else begin
              tx_byte = tx_crc_q[7:0];
              feed    = 1'b0;
            end
          end
          default: begin
            tx_byte = tx_crc_q[15:8];
            feed    = 1'b0;
          end
        endcase
      end
      mbrtu_pkg::FUNC_MVAL: begin
        if (multi_open_q) begin
          emit      = 1'b1;
          last_step = cmd.last ? (step_q == 3'd3) : (step_q == 3'd1);
          feed      = (step_q == 3'd0) || (step_q == 3'd1);
          priority case (step_q)
            3'd0:    tx_byte = cmd.value[15:8];
            3'd1:    tx_byte = cmd.value[7:0];
            3'd2:    tx_byte = tx_crc_q[7:0];
            default: tx_byte = tx_crc_q[15:8];
          endcase
        end
      end
      default: begin
        crc_in = rx_crc_q;
        if (exp_words_q != '0) begin
          if (rx_pos_q >= 8'd3 && rx_pos_q < dlen3 && !rx_pos_q[0]) begin
            emit = 1'b1;
            res.kind      = mbrtu_pkg::KIND_WORD;
            res.data_word = {held_hi_q, cmd.rx};
          end else if (rx_pos_q > dlen3) begin
            emit = 1'b1;
            res.kind   = mbrtu_pkg::KIND_STATUS;
            res.crc_ok = ({cmd.rx, crc_lo_q} == rx_crc_q);
          end
        end
      end
    endcase
    feed_byte = (cmd.op == mbrtu_pkg::FUNC_RXBYTE) ? cmd.rx : tx_byte;
    if (cmd.op != mbrtu_pkg::FUNC_RXBYTE) begin
      res.kind     = mbrtu_pkg::KIND_TX;
      res.byte_out = tx_byte;
    end
    res.frame_end = last_step;
  end

  assign fire  = head_valid_i && (can_load || !emit);
  assign pop_o = fire && last_step;

  always_comb begin
    step_d       = step_q;
    tx_crc_d     = tx_crc_q;
    rx_crc_d     = rx_crc_q;
    rx_pos_d     = rx_pos_q;
    exp_words_d  = exp_words_q;
    held_hi_d    = held_hi_q;
    crc_lo_d     = crc_lo_q;
    multi_open_d = multi_open_q;
    out_valid_d  = out_ready_i ? 1'b0 : out_valid_q;
    out_res_d    = out_res_q;
    if (fire) begin
      step_d = last_step ? '0 : step_q + 1'b1;
      if (emit) begin
        out_valid_d = 1'b1;
        out_res_d   = res;
      end
      if (cmd.op == mbrtu_pkg::FUNC_RXBYTE) begin
        if (exp_words_q != '0) begin
          if (rx_pos_q < dlen3) begin
            rx_crc_d = crc_next;
            if (rx_pos_q >= 8'd3 && rx_pos_q[0]) begin
              held_hi_d = cmd.rx;
            end
            rx_pos_d = rx_pos_q + 8'd1;
          end else if (rx_pos_q == dlen3) begin
            crc_lo_d = cmd.rx;
            rx_pos_d = rx_pos_q + 8'd1;
          end else begin
            exp_words_d = '0;
            rx_pos_d    = '0;
            rx_crc_d    = mbrtu_pkg::CRC_INIT;
          end
        end
      end else if (feed) begin
        tx_crc_d = crc_next;
      end
      if (cmd.op == mbrtu_pkg::FUNC_MHDR) begin
        multi_open_d = 1'b1;
      end
      if (cmd.op == mbrtu_pkg::FUNC_MVAL && emit && last_step && cmd.last) begin
        multi_open_d = 1'b0;
      end
      if (cmd.op == mbrtu_pkg::FUNC_READ && last_step) begin
        exp_words_d = cmd.cnt;
        rx_pos_d    = '0;
        rx_crc_d    = mbrtu_pkg::CRC_INIT;
        held_hi_d   = '0;
        crc_lo_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= '0;
      tx_crc_q     <= mbrtu_pkg::CRC_INIT;
      rx_crc_q     <= mbrtu_pkg::CRC_INIT;
      rx_pos_q     <= '0;
      exp_words_q  <= '0;
      held_hi_q    <= '0;
      crc_lo_q     <= '0;
      multi_open_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      step_q       <= step_d;
      tx_crc_q     <= tx_crc_d;
      rx_crc_q     <= rx_crc_d;
      rx_pos_q     <= rx_pos_d;
      exp_words_q  <= exp_words_d;
      held_hi_q    <= held_hi_d;
      crc_lo_q     <= crc_lo_d;
      multi_open_q <= multi_open_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

[bench/modbus_rtu_master_framer_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the Modbus RTU master framer: streams request and
// response-byte items, predicts frame bytes, read words and CRC status, and compares.
// Depends on mbrtu_pkg and modbus_rtu_master_framer.

module modbus_rtu_master_framer_test;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int ITEM_TARGET  = 280;
  localparam int DRAIN_CYCLES = 40;
  localparam int KEEP_ALL     = 1000;

  localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
  localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

  typedef struct {
    logic [2:0]  func;
    logic [7:0]  addr;
    logic [15:0] regn;
    logic [6:0]  cnt;
    logic [15:0] value;
    logic        last;
    logic [7:0]  rx;
  } req_item_t;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [55:0] s_tdata  = '0;
  logic [2:0]  s_tuser  = '0;
  logic        s_tlast  = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  req_item_t          req_items[$];
  mbrtu_pkg::result_t want_results[$];
  req_item_t          on_bus;
  mbrtu_pkg::result_t front_want;

  logic [15:0] pred_tx_crc = mbrtu_pkg::CRC_INIT;
  logic [15:0] rsp_crc     = mbrtu_pkg::CRC_INIT;
  logic [7:0]  rsp_pos     = '0;
  logic [6:0]  rsp_words   = '0;
  logic [7:0]  rsp_hi      = '0;
  logic [7:0]  rsp_crc_lo  = '0;
  logic        multi_open  = 1'b0;

  int in_gap      = 0;
  int in_calm     = 0;
  int out_hold    = 0;
  int out_calm    = 0;
  int cycles      = 0;
  int errors      = 0;
  int items_taken = 0;
  int n_tx        = 0;
  int n_word      = 0;
  int n_status    = 0;
  int n_crc_ok    = 0;

  modbus_rtu_master_framer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ mbrtu_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic mbrtu_pkg::result_t make_result(mbrtu_pkg::kind_e k, logic [7:0] b,
                                                     logic [15:0] w, logic ok);
    mbrtu_pkg::result_t r;
    r.kind      = k;
    r.byte_out  = b;
    r.data_word = w;
    r.crc_ok    = ok;
    r.frame_end = 1'b0;
    return r;
  endfunction

  function automatic int pick_gap(inout int calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic req_item_t rand_item(logic [2:0] func);
    req_item_t it;
    it.func  = func;
    it.addr  = 8'($urandom);
    it.regn  = 16'($urandom);
    it.cnt   = 7'($urandom);
    it.value = 16'($urandom);
    it.last  = 1'($urandom);
    it.rx    = 8'($urandom);
    return it;
  endfunction

  task automatic add_want(mbrtu_pkg::result_t r);
    want_results.insert(want_results.size(), r);
  endtask

  task automatic add_req(req_item_t it);
    req_items.insert(req_items.size(), it);
  endtask

  task automatic emit_tx_byte(logic [7:0] b);
    pred_tx_crc = crc16_next(pred_tx_crc, b);
    add_want(make_result(mbrtu_pkg::KIND_TX, b, 16'h0000, 1'b0));
  endtask

  task automatic emit_tx_crc();
    add_want(make_result(mbrtu_pkg::KIND_TX, pred_tx_crc[7:0], 16'h0000, 1'b0));
    add_want(make_result(mbrtu_pkg::KIND_TX, pred_tx_crc[15:8], 16'h0000, 1'b0));
  endtask

  task automatic open_frame(logic [7:0] addr, logic [7:0] fn, logic [15:0] regn);
    logic [15:0] r;
    r = regn - 16'd1;
    pred_tx_crc = mbrtu_pkg::CRC_INIT;
    emit_tx_byte(addr);
    emit_tx_byte(fn);
    emit_tx_byte(r[15:8]);
    emit_tx_byte(r[7:0]);
  endtask

  task automatic compute_framer_results(input req_item_t it);
    int          first;
    int          p;
    int          dlen;
    logic [6:0]  c;
    logic [15:0] got;
    first = want_results.size();
    c = (it.cnt > mbrtu_pkg::MAX_WORDS) ? 7'(mbrtu_pkg::MAX_WORDS) : it.cnt;
    case (it.func)
      mbrtu_pkg::FUNC_READ: begin
        open_frame(it.addr, mbrtu_pkg::FN_READ_INPUT, it.regn);
        emit_tx_byte(8'h00);
        emit_tx_byte({1'b0, c});
        emit_tx_crc();
        rsp_words  = c;
        rsp_pos    = '0;
        rsp_crc    = mbrtu_pkg::CRC_INIT;
        rsp_hi     = '0;
        rsp_crc_lo = '0;
      end
      mbrtu_pkg::FUNC_WRITE1: begin
        open_frame(it.addr, mbrtu_pkg::FN_WRITE_ONE, it.regn);
        emit_tx_byte(it.value[15:8]);
        emit_tx_byte(it.value[7:0]);
        emit_tx_crc();
      end
      mbrtu_pkg::FUNC_MHDR: begin
        open_frame(it.addr, mbrtu_pkg::FN_WRITE_MULTI, it.regn);
        emit_tx_byte(8'h00);
        emit_tx_byte({1'b0, c});
        emit_tx_byte({c, 1'b0});
        multi_open = 1'b1;
      end
      mbrtu_pkg::FUNC_MVAL: begin
        if (multi_open) begin
          emit_tx_byte(it.value[15:8]);
          emit_tx_byte(it.value[7:0]);
          if (it.last) begin
            emit_tx_crc();
            multi_open = 1'b0;
          end
        end
      end
      mbrtu_pkg::FUNC_RXBYTE: begin
        if (rsp_words != 0) begin
          p    = int'(rsp_pos);
          dlen = 2 * int'(rsp_words);
          if (p < dlen + 3) begin
            rsp_crc = crc16_next(rsp_crc, it.rx);
            if (p >= 3) begin
              if (((p - 3) % 2) == 0) begin
                rsp_hi = it.rx;
              end else begin
                add_want(make_result(mbrtu_pkg::KIND_WORD, 8'h00, {rsp_hi, it.rx}, 1'b0));
              end
            end
            rsp_pos = rsp_pos + 8'd1;
          end else if (p == dlen + 3) begin
            rsp_crc_lo = it.rx;
            rsp_pos    = rsp_pos + 8'd1;
          end else begin
            got = {it.rx, rsp_crc_lo};
            add_want(make_result(mbrtu_pkg::KIND_STATUS, 8'h00, 16'h0000, got == rsp_crc));
            rsp_words = '0;
            rsp_pos   = '0;
            rsp_crc   = mbrtu_pkg::CRC_INIT;
          end
        end
      end
      default: ;
    endcase
    if (want_results.size() > first) begin
      want_results[want_results.size() - 1].frame_end = 1'b1;
    end
  endtask

  task automatic send_read(logic [7:0] addr, logic [15:0] regn, logic [6:0] cnt);
    req_item_t it;
    it      = rand_item(mbrtu_pkg::FUNC_READ);
    it.addr = addr;
    it.regn = regn;
    it.cnt  = cnt;
    add_req(it);
  endtask

  task automatic send_write1(logic [7:0] addr, logic [15:0] regn, logic [15:0] value);
    req_item_t it;
    it       = rand_item(mbrtu_pkg::FUNC_WRITE1);
    it.addr  = addr;
    it.regn  = regn;
    it.value = value;
    add_req(it);
  endtask

  task automatic send_multi(logic [7:0] addr, logic [15:0] regn, logic [6:0] cnt,
                            int nvals, bit close);
    req_item_t it;
    it      = rand_item(mbrtu_pkg::FUNC_MHDR);
    it.addr = addr;
    it.regn = regn;
    it.cnt  = cnt;
    add_req(it);
    for (int i = 0; i < nvals; i++) begin
      it      = rand_item(mbrtu_pkg::FUNC_MVAL);
      it.last = close && (i == nvals - 1);
      add_req(it);
    end
  endtask

  // Fault 1 corrupts a counted byte, fault 2 a CRC byte; keep truncates the
  // response and write_at slips a write single in before that byte.
  task automatic send_response(int words, int fault, int keep, int write_at);
    logic [7:0]  rsp_bytes[$];
    logic [15:0] crc;
    req_item_t   it;
    int          idx;
    rsp_bytes.insert(rsp_bytes.size(), 8'($urandom));
    rsp_bytes.insert(rsp_bytes.size(), mbrtu_pkg::FN_READ_INPUT);
    rsp_bytes.insert(rsp_bytes.size(), 8'(2 * words));
    for (int i = 0; i < 2 * words; i++) rsp_bytes.insert(rsp_bytes.size(), 8'($urandom));
    crc = mbrtu_pkg::CRC_INIT;
    foreach (rsp_bytes[i]) crc = crc16_next(crc, rsp_bytes[i]);
    rsp_bytes.insert(rsp_bytes.size(), crc[7:0]);
    rsp_bytes.insert(rsp_bytes.size(), crc[15:8]);
    if (fault == 1) begin
      idx = $urandom_range(0, rsp_bytes.size() - 3);
      rsp_bytes[idx] ^= 8'(1 << $urandom_range(0, 7));
    end else if (fault == 2) begin
      idx = $urandom_range(rsp_bytes.size() - 2, rsp_bytes.size() - 1);
      rsp_bytes[idx] ^= 8'(1 << $urandom_range(0, 7));
    end
    for (int i = 0; i < rsp_bytes.size() && i < keep; i++) begin
      if (i == write_at) send_write1(8'($urandom), 16'($urandom), 16'($urandom));
      it    = rand_item(mbrtu_pkg::FUNC_RXBYTE);
      it.rx = rsp_bytes[i];
      add_req(it);
    end
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        compute_framer_results(on_bus);
        items_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          s_tvalid <= 1'b0;
        end else if (req_items.size() != 0) begin
          on_bus = req_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {1'b0, on_bus.rx, on_bus.value, on_bus.cnt, on_bus.regn, on_bus.addr};
          s_tuser  <= on_bus.func;
          s_tlast  <= on_bus.last;
          in_gap = pick_gap(in_calm);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (out_hold > 0) begin
      out_hold--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      out_hold = pick_gap(out_calm);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      if (want_results.size() == 0) begin
        $error("result with nothing expected: kind %0d, tdata %h, tlast %0d",
               m_tuser, m_tdata, m_tlast);
        errors++;
      end else begin
        front_want = want_results.pop_front();
        check_field("kind", front_want.kind, m_tuser);
        check_field("byte_out", front_want.byte_out, m_tdata[7:0]);
        check_field("data_word", front_want.data_word, $signed(m_tdata[23:8]));
        check_field("crc_ok", front_want.crc_ok, m_tdata[24]);
        check_field("frame_end", front_want.frame_end, m_tlast);
      end
      case (m_tuser)
        mbrtu_pkg::KIND_TX:     n_tx++;
        mbrtu_pkg::KIND_WORD:   n_word++;
        mbrtu_pkg::KIND_STATUS: begin
          n_status++;
          if (m_tdata[24]) n_crc_ok++;
        end
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycles, want_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int        pick;
    int        cnt;
    int        words;
    int        r;
    int        fault;
    int        keep;
    int        wat;
    int        n;
    int        vals;
    int        left;
    req_item_t it;

    // Register zero wraps to 0xFFFF on the wire; a write single lands mid-response.
    send_read(8'h00, 16'h0000, 7'd1);
    send_response(1, 0, KEEP_ALL, 4);
    // A zero-count read leaves nothing pending, so the next response byte is dropped.
    send_read(8'hFF, 16'hFFFF, 7'd0);
    add_req(rand_item(mbrtu_pkg::FUNC_RXBYTE));
    send_write1(8'hFF, 16'hFFFF, 16'hFFFF);
    send_write1(8'h00, 16'h0001, 16'h0000);
    it      = rand_item(mbrtu_pkg::FUNC_MVAL);
    it.last = 1'b1;
    add_req(it);
    send_multi(8'h11, 16'h0001, 7'd2, 1, 1'b0);
    send_multi(8'h22, 16'h8000, 7'd1, 1, 1'b1);
    for (int f = FUNC_UNUSED_LO; f <= FUNC_UNUSED_HI; f++) begin
      add_req(rand_item(3'(f)));
    end
    // An oversized count saturates, and a new read abandons its parse.
    send_read(8'h5A, 16'h1234, 7'd127);
    send_read(8'hA5, 16'h4321, 7'd1);
    send_response(1, 2, KEEP_ALL, -1);

    // Responses are cut short where they would run past the item budget.
    while (req_items.size() < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 38) begin
        cnt   = ($urandom_range(0, 99) < 3) ? $urandom_range(100, 127) : $urandom_range(1, 4);
        words = (cnt > int'(mbrtu_pkg::MAX_WORDS)) ? int'(mbrtu_pkg::MAX_WORDS) : cnt;
        r     = $urandom_range(0, 99);
        fault = (r < 70) ? 0 : ((r < 85) ? 1 : 2);
        keep  = ($urandom_range(0, 99) < 8) ? $urandom_range(0, 2 * words + 4) : KEEP_ALL;
        wat   = ($urandom_range(0, 99) < 12) ? $urandom_range(1, 2 * words + 4) : -1;
        left  = ITEM_TARGET - req_items.size();
        if (keep > left) keep = left;
        send_read(8'($urandom), 16'($urandom), 7'(cnt));
        send_response(words, fault, keep, wat);
      end else if (pick < 55) begin
        send_write1(8'($urandom), 16'($urandom), 16'($urandom));
      end else if (pick < 80) begin
        n    = $urandom_range(1, 5);
        vals = ($urandom_range(0, 99) < 85) ? n : $urandom_range(0, 6);
        send_multi(8'($urandom), 16'($urandom), 7'(n), vals, $urandom_range(0, 9) != 0);
      end else begin
        add_req(rand_item(3'($urandom_range(0, 7))));
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_items.size() != 0 || s_tvalid || want_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (want_results.size() != 0) begin
      $error("%0d expected results never arrived", want_results.size());
      errors++;
    end
    $display("Sent %0d items; checked %0d frame bytes and %0d read words.",
             items_taken, n_tx, n_word);
    $display("Saw %0d read statuses, %0d of them with a CRC match; %0d errors.",
             n_status, n_crc_ok, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/mbrtu_pkg.sv
rtl/mbrtu_front.sv
rtl/mbrtu_queue.sv
rtl/mbrtu_back.sv
rtl/modbus_rtu_master_framer.sv
bench/modbus_rtu_master_framer_test.sv
